### rtl/core/cdq_pkg.sv
package cdq_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // field widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;
  localparam int VALUE_W  = 32;

  // operation codes, anything else is a query
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic exec;
    logic read;
    logic load;
  } cdq_cmd_t;

endpackage

### rtl/core/cdq_if.sv
interface cdq_in_if import cdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           op;
  logic signed [VALUE_W-1:0] data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic [CAP_W-1:0]          count;
  logic                      is_empty;
  logic                      is_full;

  modport source (output valid, output status, output front_value, output rear_value,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_value, input rear_value,
                  input count, input is_empty, input is_full, output ready);
endinterface

### rtl/core/cdq_ctrl.sv
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cdq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/cdq_dpath.sv
module cdq_dpath import cdq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cdq_cmd_t                  cmd_i,
  input  logic [OP_W-1:0]           op_i,
  input  logic signed [VALUE_W-1:0] data_in_i,
  input  logic                      cfg_we_i,
  input  logic [CAP_W-1:0]          cfg_wdata_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [VALUE_W-1:0] front_value_o,
  output logic signed [VALUE_W-1:0] rear_value_o,
  output logic [CAP_W-1:0]          count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o
);

  // reduce a position sum known to be below twice the capacity
  function automatic logic [PTR_W-1:0] wrap_pos(logic [SUM_W-1:0] s, logic [CNT_W-1:0] cap);
    logic [SUM_W-1:0] r;
    r = s;
    if (s >= SUM_W'(cap)) begin
      r = s - SUM_W'(cap);
    end
    return r[PTR_W-1:0];
  endfunction

  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      cap_eff;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [OP_W-1:0]       op_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [STATUS_W-1:0]   status_q, status_d;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_rear_q;
  logic [PTR_W-1:0]      rear_addr;

  logic                  st_full, st_empty;
  logic [PTR_W-1:0]      head_dec, head_inc, rear_ins;

  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_front_q, out_rear_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_empty_q, out_full_q;

  // zero acts as one, anything past the store acts as the store size
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign st_full  = (cnt_q == cap_eff);
  assign st_empty = (cnt_q == '0);
  assign head_dec = (head_q == '0) ? PTR_W'(cap_eff - CNT_W'(1)) : head_q - PTR_W'(1);
  assign head_inc = wrap_pos(SUM_W'(head_q) + SUM_W'(1), cap_eff);
  assign rear_ins = wrap_pos(SUM_W'(head_q) + SUM_W'(cnt_q), cap_eff);
  assign rear_addr = wrap_pos(SUM_W'(head_q) + SUM_W'(cnt_q) - SUM_W'(1), cap_eff);

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    status_d = ST_DONE;
    wr_en    = 1'b0;
    wr_addr  = rear_ins;
    unique case (op_q)
      OP_INS_FRONT: begin
        if (st_full) begin
          status_d = ST_FULL;
        end else begin
          head_d  = head_dec;
          cnt_d   = cnt_q + CNT_W'(1);
          wr_en   = cmd_i.exec;
          wr_addr = head_dec;
        end
      end
      OP_INS_REAR: begin
        if (st_full) begin
          status_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
          wr_en = cmd_i.exec;
        end
      end
      OP_DEL_FRONT: begin
        if (st_empty) begin
          status_d = ST_EMPTY;
        end else begin
          head_d = head_inc;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      OP_DEL_REAR: begin
        if (st_empty) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_W'(DEPTH);
      head_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      cap_q  <= cfg_wdata_i;
      head_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      data_q <= DATA_WIDTH'(data_in_i);
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_rear_q  <= mem_q[rear_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_q <= status_q;
      out_front_q  <= st_empty ? '0 : VALUE_W'(rd_front_q);
      out_rear_q   <= st_empty ? '0 : VALUE_W'(rd_rear_q);
      out_cnt_q    <= cnt_q;
      out_empty_q  <= st_empty;
      out_full_q   <= st_full;
    end
  end

  assign status_o      = out_status_q;
  assign front_value_o = out_front_q;
  assign rear_value_o  = out_rear_q;
  assign count_o       = CAP_W'(out_cnt_q);
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule

### rtl/core/circular_deque_engine.sv
// a result passes the update, store read and load steps after the input transfer; load waits for a free output register
// one item at a time: a new item is taken only after the accept, update, store read and load steps of the last
// the store read of front and rear is registered and follows the update step
// reset: pointer and count go to zero, capacity to sixteen, no result pending
// store contents are not cleared by reset and need no clearing pass
module circular_deque_engine import cdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdq_in_if.sink           in_i,
  cdq_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  // command bundle from the sequencer to the datapath
  cdq_cmd_t cmd;

  // sequencer: idle, update pointers and store, read front and rear, load result
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // datapath: capacity register, head and count, element store, output register
  cdq_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (in_i.op),
    .data_in_i     (in_i.data_in),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (out_o.status),
    .front_value_o (out_o.front_value),
    .rear_value_o  (out_o.rear_value),
    .count_o       (out_o.count),
    .is_empty_o    (out_o.is_empty),
    .is_full_o     (out_o.is_full)
  );

`ifndef SYNTHESIS
  // a refused insert must report a full deque
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_FULL) |-> out_o.is_full)
    else $error("full refusal without full flag");

  // a refused delete must report an empty deque
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == ST_EMPTY) |-> out_o.is_empty)
    else $error("empty refusal without empty flag");

  // an empty deque shows zero values and zero count
  a_empty_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_empty) |->
      (out_o.front_value == 0 && out_o.rear_value == 0 && out_o.count == 0))
    else $error("empty deque with nonzero fields");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while busy");
`endif

endmodule

### sim/circular_deque_engine_test.sv
`timescale 1ns / 1ps

module circular_deque_engine_test;
  import cdq_pkg::*;

  // op codes outside the defined set, the block treats them as a query
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  // idle wait after draining, used before a capacity write and at the end of the run
  localparam int SETTLE_CYCLES = 8;
  localparam int HALF_PERIOD   = 10;

  // one result transfer as the block presents it
  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] rear_value;
    logic [CAP_W-1:0]          count;
    logic                      is_empty;
    logic                      is_full;
  } deque_view_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  cdq_in_if  dq_in ();
  cdq_out_if dq_out ();

  circular_deque_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (dq_in),
    .out_o       (dq_out),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // shadow copy of the deque: store, head position, element count, capacity register
  logic signed [VALUE_W-1:0] shadow_store [DEPTH];
  int                        shadow_head;
  int                        shadow_count;
  logic [CAP_W-1:0]          shadow_cap;

  // views predicted for accepted items, oldest first
  deque_view_t pending_views [$];

  // idle and stall knobs, per cycle percentages
  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold;

  int fail_count;
  int n_items;
  int n_checked;
  int n_full_refused;
  int n_empty_refused;
  int n_cap_writes;

  // position arithmetic that wraps at the effective capacity
  function automatic int wrap_pos(int a, int b, int cap);
    int s;
    s = a + b;
    if (s >= cap) s -= cap;
    return s;
  endfunction

  // apply one operation to the shadow deque and return the view it should produce
  function automatic deque_view_t apply_deque_op(logic [OP_W-1:0] op,
                                                 logic signed [VALUE_W-1:0] value);
    deque_view_t v;
    int          cap;
    int          head;
    int          cnt;
    // capacity 0 behaves as 1, anything above the store depth as the depth
    cap = int'(shadow_cap);
    if (cap < 1) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    head = shadow_head % cap;
    cnt  = (shadow_count > cap) ? cap : shadow_count;
    v.status = ST_DONE;
    case (op)
      OP_INS_FRONT: begin
        if (cnt == cap) begin
          v.status = ST_FULL;
        end else begin
          head = wrap_pos(head, cap - 1, cap);
          shadow_store[head] = value;
          cnt++;
        end
      end
      OP_INS_REAR: begin
        if (cnt == cap) begin
          v.status = ST_FULL;
        end else begin
          shadow_store[wrap_pos(head, cnt, cap)] = value;
          cnt++;
        end
      end
      OP_DEL_FRONT: begin
        if (cnt == 0) begin
          v.status = ST_EMPTY;
        end else begin
          head = wrap_pos(head, 1, cap);
          cnt--;
        end
      end
      OP_DEL_REAR: begin
        if (cnt == 0) begin
          v.status = ST_EMPTY;
        end else begin
          cnt--;
        end
      end
      default: begin
      end
    endcase
    shadow_head  = head;
    shadow_count = cnt;
    if (v.status == ST_FULL) n_full_refused++;
    if (v.status == ST_EMPTY) n_empty_refused++;
    // front and rear read as zero while the deque is empty
    v.front_value = (cnt != 0) ? shadow_store[head] : '0;
    v.rear_value  = (cnt != 0) ? shadow_store[wrap_pos(head, cnt - 1, cap)] : '0;
    v.count       = CAP_W'(cnt);
    v.is_empty    = (cnt == 0);
    v.is_full     = (cnt == cap);
    return v;
  endfunction

  // offer one item, with random idle cycles first, and wait for the transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      dq_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    dq_in.valid   <= 1'b1;
    dq_in.op      <= op;
    dq_in.data_in <= value;
    // valid is high before this edge, so ready seen here completes the transfer
    do @(posedge clk_i); while (!dq_in.ready);
    pending_views.push_back(apply_deque_op(op, value));
    n_items++;
  endtask

  // stop offering and wait until every predicted view has been checked
  task automatic wait_drained();
    dq_in.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // capacity is only written with the block idle; any write empties the deque
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk_i);
    cfg_we       <= 1'b0;
    shadow_cap   = cap;
    shadow_head  = 0;
    shadow_count = 0;
    n_cap_writes++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    // extremes now and then, otherwise a full random word
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_rsvd_pick();
    case ($urandom_range(2))
      0:       return OP_RSVD_5;
      1:       return OP_RSVD_6;
      default: return OP_RSVD_7;
    endcase
  endfunction

  // ops drawn with a fill tendency that flips every burst, so the deque swings
  // between empty and full and both refusals come up often
  task automatic run_traffic(input int n);
    int fill_pct;
    int burst;
    int r;
    logic [OP_W-1:0] op;
    fill_pct = 70;
    burst    = 0;
    repeat (n) begin
      if (burst == 0) begin
        burst    = $urandom_range(4, 30);
        fill_pct = (fill_pct > 50) ? $urandom_range(15, 35) : $urandom_range(65, 85);
      end
      burst--;
      r = $urandom_range(99);
      if (r < fill_pct)
        op = $urandom_range(1) ? OP_INS_REAR : OP_INS_FRONT;
      else if (r < 92)
        op = $urandom_range(1) ? OP_DEL_REAR : OP_DEL_FRONT;
      else if (r < 96)
        op = OP_QUERY;
      else
        op = OP_OP_rsvd_pick();
      send_item(op, pick_value());
    end
  endtask

  // deletes and queries on an empty deque, plus the undefined op codes
  task automatic test_empty_refusals();
    send_item(OP_DEL_FRONT, 32'sd5);
    send_item(OP_DEL_REAR, -32'sd5);
    send_item(OP_QUERY, '0);
    send_item(OP_RSVD_5, -32'sd1);
    send_item(OP_RSVD_6, 32'sh7FFF_FFFF);
    send_item(OP_RSVD_7, 32'sh8000_0000);
  endtask

  // extreme values at both ends, then removal from both ends
  task automatic test_value_extremes();
    send_item(OP_INS_FRONT, 32'sh7FFF_FFFF);
    send_item(OP_INS_REAR, 32'sh8000_0000);
    send_item(OP_INS_FRONT, -32'sd1);
    send_item(OP_INS_REAR, '0);
    send_item(OP_DEL_FRONT, '0);
    send_item(OP_DEL_REAR, '0);
    send_item(OP_QUERY, '0);
  endtask

  // single entry deque, and capacity zero which behaves the same
  task automatic test_capacity_one();
    write_capacity(5'd1);
    send_item(OP_INS_REAR, 32'sh1234_5678);
    send_item(OP_INS_FRONT, -32'sd7);
    send_item(OP_QUERY, '0);
    send_item(OP_DEL_FRONT, '0);
    send_item(OP_DEL_REAR, '0);
    write_capacity(5'd0);
    send_item(OP_INS_FRONT, 32'sh0BAD_F00D);
    send_item(OP_INS_REAR, 32'sh7FFF_FFFF);
  endtask

  // random traffic under each idling mode and a spread of capacities,
  // including the out of range ones that clamp to the store depth
  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [12];
    int               send_pct [4];
    int               recv_pct [4];
    caps     = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd17, 5'd1,
                 5'd8, 5'd0, 5'd15, 5'd3, 5'd16, 5'd4};
    send_pct = '{0, 84, 0, 21};
    recv_pct = '{0, 0, 84, 21};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      for (int c = 0; c < 3; c++) begin
        write_capacity(caps[p * 3 + c]);
        run_traffic(130);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block backs up
  // and stalls its input; then the sender pauses until all results are in
  task automatic test_backpressure();
    write_capacity(5'd16);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold      = 300;
    run_traffic(40);
    wait_drained();
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    run_traffic(40);
  endtask

  // result side: check each result transfer, then choose ready for the next cycle
  initial begin
    deque_view_t want;
    dq_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (dq_out.valid && dq_out.ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: result transfer with nothing predicted, status %0d count %0d",
                   $time, dq_out.status, dq_out.count);
          fail_count++;
        end else begin
          want = pending_views.pop_front();
          n_checked++;
          if (dq_out.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, dq_out.status);
            fail_count++;
          end
          if (dq_out.front_value !== want.front_value) begin
            $display("%0t: front_value expected %h actual %h",
                     $time, want.front_value, dq_out.front_value);
            fail_count++;
          end
          if (dq_out.rear_value !== want.rear_value) begin
            $display("%0t: rear_value expected %h actual %h",
                     $time, want.rear_value, dq_out.rear_value);
            fail_count++;
          end
          if (dq_out.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, dq_out.count);
            fail_count++;
          end
          if (dq_out.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b actual %b",
                     $time, want.is_empty, dq_out.is_empty);
            fail_count++;
          end
          if (dq_out.is_full !== want.is_full) begin
            $display("%0t: is_full expected %b actual %b", $time, want.is_full, dq_out.is_full);
            fail_count++;
          end
        end
      end
      // a hold-off counts down in cycles here, otherwise stall at random
      if (recv_hold > 0) begin
        dq_out.ready <= 1'b0;
        recv_hold--;
      end else begin
        dq_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    dq_in.valid   <= 1'b0;
    dq_in.op      <= OP_QUERY;
    dq_in.data_in <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    recv_hold       = 0;
    fail_count      = 0;
    n_items         = 0;
    n_checked       = 0;
    n_full_refused  = 0;
    n_empty_refused = 0;
    n_cap_writes    = 0;
    // reset state: empty deque, capacity sixteen
    shadow_head  = 0;
    shadow_count = 0;
    shadow_cap   = 5'd16;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_refusals();
    test_value_extremes();
    test_capacity_one();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d transfers over %0d capacity settings: %0d full and %0d empty refusals",
             n_items, n_cap_writes + 1, n_full_refused, n_empty_refused);
    $display("%0d results compared field by field against the predicted deque", n_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_views.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_if.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dpath.sv
rtl/core/circular_deque_engine.sv
sim/circular_deque_engine_test.sv
